@@ hw/rtl/bez_pkg.sv @@
// bez_pkg: shared types, constants and the de casteljau blend function
// for the cubic bezier bisection solver; no dependencies
`default_nettype none

package bez_pkg;

    localparam int MAX_HALVINGS = 20;
    localparam int FRAC_BITS    = 16;
    localparam int T_W          = FRAC_BITS + 1;
    localparam int CNT_W        = 6;
    localparam int NUM_STEPS    = MAX_HALVINGS + 1;
    localparam int PROD_W       = 33 + T_W + 1;

    localparam logic [15:0] TOL_RESET = 16'd7;

    // register indexes
    localparam logic [1:0] REG_TOLERANCE = 2'd0;

    localparam logic [T_W-1:0] T_ONE  = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0] T_HALF = T_W'(1) << (FRAC_BITS - 1);

    typedef struct packed {
        logic signed [31:0] target_value;
        logic signed [31:0] ctrl_p0;
        logic signed [31:0] ctrl_p1;
        logic signed [31:0] ctrl_p2;
        logic signed [31:0] ctrl_p3;
    } t_in_item;

    typedef struct packed {
        logic [16:0]      param_t;
        logic             converged;
        logic [CNT_W-1:0] halvings_used;
    } t_out_item;

    // search state carried along the pipeline
    typedef struct packed {
        logic             done;
        logic             ok;
        t_in_item         item;
        logic [T_W-1:0]   lo;
        logic [T_W-1:0]   hi;
        logic [T_W-1:0]   t;
        logic [CNT_W-1:0] count;
    } t_work;

    // p + floor(((q - p) * t + half) / 2^FRAC_BITS)
    function automatic logic signed [31:0] blend(
        input logic signed [31:0] p,
        input logic signed [31:0] q,
        input logic [T_W-1:0]     t
    );
        logic signed [32:0]       diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] r;
        logic signed [PROD_W-1:0] s;
        diff = 33'(q) - 33'(p);
        prod = PROD_W'(diff) * $signed({1'b0, t});
        r    = (prod + (PROD_W'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        s    = r + PROD_W'(p);
        return s[31:0];
    endfunction

    function automatic logic [16:0] t_to_q16(input logic [T_W-1:0] t);
        logic [16:0] res;
        if (FRAC_BITS >= 16) begin
            res = 17'(t >> (FRAC_BITS - 16));
        end else begin
            res = 17'(t) << (16 - FRAC_BITS);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/bez_step.sv @@
// bez_step: one bisection step as four register stages
// (three de casteljau levels, then tolerance check and bound update); uses bez_pkg
`default_nettype none

module bez_step (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_adv,
    input  wire logic [15:0]    i_tol,
    input  wire logic           i_valid,
    input  wire bez_pkg::t_work i_work,
    output logic                o_valid,
    output bez_pkg::t_work      o_work
);

    logic [3:0] r_v;
    bez_pkg::t_work r_w1, r_w2, r_w3, r_w4;
    logic signed [31:0] r_a, r_b, r_c, r_d, r_e, r_x;
    bez_pkg::t_work n_w4;

    logic signed [32:0] diff;
    logic        [32:0] absd;

    always_comb begin
        n_w4 = r_w3;
        diff = 33'(r_w3.item.target_value) - 33'(r_x);
        absd = diff[32] ? 33'(-diff) : 33'(diff);
        if (!r_w3.done) begin
            if (absd <= {17'd0, i_tol}) begin
                n_w4.done = 1'b1;
                n_w4.ok   = 1'b1;
            end else if (r_w3.count == bez_pkg::CNT_W'(bez_pkg::MAX_HALVINGS)) begin
                n_w4.done = 1'b1;
                n_w4.ok   = 1'b0;
            end else begin
                if (diff[32] == 1'b0) begin
                    n_w4.lo = r_w3.t;
                    n_w4.t  = bez_pkg::T_W'(({1'b0, r_w3.t} + {1'b0, r_w3.hi}) >> 1);
                end else begin
                    n_w4.hi = r_w3.t;
                    n_w4.t  = bez_pkg::T_W'(({1'b0, r_w3.lo} + {1'b0, r_w3.t}) >> 1);
                end
                n_w4.count = r_w3.count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_adv) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_w1 <= i_work;
            r_a  <= bez_pkg::blend(i_work.item.ctrl_p0, i_work.item.ctrl_p1, i_work.t);
            r_b  <= bez_pkg::blend(i_work.item.ctrl_p1, i_work.item.ctrl_p2, i_work.t);
            r_c  <= bez_pkg::blend(i_work.item.ctrl_p2, i_work.item.ctrl_p3, i_work.t);
            r_w2 <= r_w1;
            r_d  <= bez_pkg::blend(r_a, r_b, r_w1.t);
            r_e  <= bez_pkg::blend(r_b, r_c, r_w1.t);
            r_w3 <= r_w2;
            r_x  <= bez_pkg::blend(r_d, r_e, r_w2.t);
            r_w4 <= n_w4;
        end
    end

    assign o_valid = r_v[3];
    assign o_work  = r_w4;

endmodule

`default_nettype wire

@@ hw/rtl/cubic_bezier_bisection_solver.sv @@
// cubic_bezier_bisection_solver: top level, apb tolerance register and a chain
// of bisection steps; uses bez_pkg and bez_step
`default_nettype none

// usage
//   input channel: i_valid / o_stall with i_data (target and four control values,
//   signed q16.16); an item is taken at a clock edge with i_valid high, o_stall low
//   output channel: o_valid / i_stall with o_data (param_t in q1.16, converged,
//   halvings_used); one result item per input item, in order
//   apb port: one register, tolerance at address 0, reset value 7; write only
//   while no item is in flight
//   pipeline: every step evaluates the cubic in three register stages and
//   checks and updates the bounds in a fourth
//   throughput: one item per cycle unless stalled, the chain holds up to 84 items;
//   an item that meets the tolerance early just rides the remaining steps unchanged
//   reset: synchronous, active low; clears all valid bits and sets tolerance to 7
//   stall: while a result waits with i_stall high the whole chain freezes and
//   o_stall is raised, so nothing is lost or repeated
module cubic_bezier_bisection_solver (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire bez_pkg::t_in_item i_data,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output bez_pkg::t_out_item     o_data,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [3:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [15:0] r_tol;
    logic        adv;

    // chain links, index 0 feeds the first step
    logic           v_link [bez_pkg::NUM_STEPS+1];
    bez_pkg::t_work w_link [bez_pkg::NUM_STEPS+1];

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= bez_pkg::TOL_RESET;
        end else if (psel && penable && pwrite && paddr[3:2] == bez_pkg::REG_TOLERANCE) begin
            r_tol <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[3:2] == bez_pkg::REG_TOLERANCE) ? {16'd0, r_tol} : 32'd0;

    // chain moves unless a finished result is held back
    assign adv     = !(v_link[bez_pkg::NUM_STEPS] && i_stall);
    assign o_stall = !adv;

    // fresh search: bounds [0,1], first t at one half
    always_comb begin
        v_link[0]       = i_valid;
        w_link[0].done  = 1'b0;
        w_link[0].ok    = 1'b0;
        w_link[0].item  = i_data;
        w_link[0].lo    = '0;
        w_link[0].hi    = bez_pkg::T_ONE;
        w_link[0].t     = bez_pkg::T_HALF;
        w_link[0].count = '0;
    end

    for (genvar k = 0; k < bez_pkg::NUM_STEPS; k++) begin : g_step
        bez_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_tol   (r_tol),
            .i_valid (v_link[k]),
            .i_work  (w_link[k]),
            .o_valid (v_link[k+1]),
            .o_work  (w_link[k+1])
        );
    end

    // last step's registers serve as the output register
    assign o_valid              = v_link[bez_pkg::NUM_STEPS];
    assign o_data.param_t       = bez_pkg::t_to_q16(w_link[bez_pkg::NUM_STEPS].t);
    assign o_data.converged     = w_link[bez_pkg::NUM_STEPS].ok;
    assign o_data.halvings_used = w_link[bez_pkg::NUM_STEPS].count;

endmodule

`default_nettype wire
